@@ sv/kpsc_pkg.sv @@
// Package for the keyed printable shift cipher unit.
// Holds the shared types, constants, and the key byte select function.
// No dependencies.
package kpsc_pkg;

  // Key geometry
  localparam int KEY_MAX = 16;
  localparam int KEY_IDX_W = $clog2(KEY_MAX);
  localparam int KEY_LEN_W = $clog2(KEY_MAX + 1);
  localparam int KEY_SUM_W = 12;

  // Character classes
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;
  localparam logic [7:0] PRINT_MOD = 8'd95;
  localparam logic [7:0] CTRL_LO = 8'd9;
  localparam logic [7:0] CTRL_HI = 8'd11;
  localparam logic [7:0] CTRL_MOD = 8'd3;

  // Configuration register indexes
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t CFG_DECRYPT_MODE = 3'd0;
  localparam cfg_index_t CFG_PASS_COUNT = 3'd1;
  localparam cfg_index_t CFG_KEY_LENGTH = 3'd2;
  localparam cfg_index_t CFG_KEY_BYTES_LOW = 3'd3;
  localparam cfg_index_t CFG_KEY_BYTES_HIGH = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_KEY,
    ST_PASS,
    ST_WRITE
  } kpsc_state_t;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_PRINT,
    CLS_CTRL
  } kpsc_class_t;

  typedef enum logic [1:0] {
    OP_ADD_MOD,
    OP_SUB_MOD,
    OP_SUB_GE
  } kpsc_op_t;

  // Request to the shared add/subtract unit
  typedef struct packed {
    kpsc_op_t   op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] m;
  } kpsc_alu_req_t;

  // Pick key byte idx out of the two 64-bit key words
  function automatic logic [7:0] key_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [KEY_IDX_W-1:0] idx);
    logic [127:0] all;
    all = {hi, lo};
    return all[{idx, 3'b000} +: 8];
  endfunction

endpackage

@@ sv/kpsc_if.sv @@
// Channel interfaces of the keyed printable shift cipher unit.
// Input item, result item and configuration write channels.
// Depends on kpsc_pkg.
interface kpsc_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_start;

  modport source (output valid, output data_byte, output message_start, input ready);
  modport sink (input valid, input data_byte, input message_start, output ready);
endinterface

interface kpsc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink (input valid, input result_byte, output ready);
endinterface

interface kpsc_cfg_if;
  logic                 valid;
  logic                 ready;
  kpsc_pkg::cfg_index_t index;
  logic [63:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/kpsc_alu.sv @@
// Shared 8-bit add/subtract unit with modular correction.
// Serves the remainder steps and the cipher passes.
// Depends on kpsc_pkg.
module kpsc_alu (
  input  kpsc_pkg::kpsc_alu_req_t req,
  output logic [7:0]              res
);
  import kpsc_pkg::*;

  logic [8:0] sum;
  logic [8:0] diff;
  logic [8:0] wrap_add;
  logic       ge;

  // Form the raw sum and difference once
  always_comb begin
    sum = {1'b0, req.a} + {1'b0, req.b};
    diff = {1'b0, req.a} - {1'b0, req.b};
    wrap_add = sum - {1'b0, req.m};
    ge = (req.a >= req.b);
  end

  // Apply the correction for the requested operation
  always_comb begin
    case (req.op)
      OP_ADD_MOD: res = (sum >= {1'b0, req.m}) ? wrap_add[7:0] : sum[7:0];
      OP_SUB_MOD: res = ge ? diff[7:0] : (diff[7:0] + req.m);
      OP_SUB_GE:  res = ge ? diff[7:0] : req.a;
      default:    res = req.a;
    endcase
  end
endmodule

@@ sv/keyed_printable_shift_cipher_unit.sv @@
// Top level of the keyed printable shift cipher unit.
// Uses kpsc_pkg, the channel interfaces in kpsc_if and the shared unit kpsc_alu.
//
//   channel      modport  payload                       role
//   data_item    sink     data_byte, message_start      bytes to transform
//   data_result  source   result_byte                   transformed bytes
//   config_wr    sink     index, data                   register writes
//
// A byte goes through KEY, pass_count passes (none for bytes outside both classes) and
// WRITE; with message_start set, SUM first adds the key bytes over the clamped key
// length (1..16), one a cycle, then DIV takes a 12-step remainder. DIV and the passes,
// one a cycle, use the shared unit. rst is synchronous and resets control state and the
// configuration registers. A stalled result waits in the output register; the next
// byte may be taken meanwhile and holds in its last state until the register frees.
module keyed_printable_shift_cipher_unit (
  input logic                  clk,
  input logic                  rst,
  kpsc_item_if.sink            data_item,
  kpsc_result_if.source        data_result,
  kpsc_cfg_if.sink             config_wr
);
  import kpsc_pkg::*;

  // Configuration registers
  logic                 decrypt_mode;
  logic [1:0]           pass_count;
  logic [4:0]           key_length;
  logic [63:0]          key_bytes_low;
  logic [63:0]          key_bytes_high;

  // Control state
  kpsc_state_t          state;
  kpsc_state_t          state_next;
  logic [KEY_IDX_W-1:0] key_position;
  logic                 out_valid;

  // Item working registers
  logic [7:0]           char_in;
  kpsc_class_t          char_class;
  logic [6:0]           char_val;
  logic [6:0]           shift;
  logic [1:0]           pass_left;
  logic [KEY_SUM_W-1:0] key_sum;
  logic [KEY_IDX_W-1:0] sum_cnt;
  logic [3:0]           bit_cnt;
  logic [4:0]           rem;
  logic [7:0]           result_byte;

  // Combinational helpers
  logic [KEY_LEN_W-1:0] n_eff;
  logic [KEY_IDX_W-1:0] idx;
  logic [KEY_LEN_W-1:0] idx_inc;
  logic [7:0]           kbyte;
  logic [6:0]           s95;
  logic [15:0]          prod3;
  logic [6:0]           q3;
  logic [7:0]           r3;
  logic                 accept;
  logic                 out_free;
  logic                 sum_last;
  kpsc_alu_req_t        alu_req;
  logic [7:0]           alu_res;

  assign accept = data_item.valid && data_item.ready;
  assign out_free = !out_valid || data_result.ready;
  assign data_item.ready = (state == ST_IDLE);
  assign config_wr.ready = 1'b1;
  assign data_result.valid = out_valid;
  assign data_result.result_byte = result_byte;

  // Clamp the key length to 1..KEY_MAX
  always_comb begin
    if (key_length == '0) begin
      n_eff = KEY_LEN_W'(1);
    end else if (key_length > KEY_LEN_W'(KEY_MAX)) begin
      n_eff = KEY_LEN_W'(KEY_MAX);
    end else begin
      n_eff = key_length;
    end
  end

  // Key byte for this item and its shifts modulo 95 and 3
  always_comb begin
    idx = ({1'b0, key_position} >= n_eff) ? '0 : key_position;
    idx_inc = {1'b0, idx} + KEY_LEN_W'(1);
    kbyte = key_byte(key_bytes_low, key_bytes_high, idx);
    if (kbyte >= 8'd190) begin
      s95 = 7'(kbyte - 8'd190);
    end else if (kbyte >= PRINT_MOD) begin
      s95 = 7'(kbyte - PRINT_MOD);
    end else begin
      s95 = kbyte[6:0];
    end
    prod3 = {8'b0, kbyte} * 16'd171;
    q3 = prod3[15:9];
    r3 = kbyte - {q3, 1'b0} - {1'b0, q3};
    sum_last = ({1'b0, sum_cnt} == (n_eff - KEY_LEN_W'(1)));
  end

  // Drive the shared unit from the active state
  always_comb begin
    alu_req = '{op: OP_SUB_GE, a: 8'b0, b: 8'b0, m: 8'b0};
    case (state)
      ST_DIV: begin
        alu_req.op = OP_SUB_GE;
        alu_req.a = {2'b0, rem, key_sum[KEY_SUM_W-1]};
        alu_req.b = {3'b0, n_eff};
      end
      ST_PASS: begin
        alu_req.op = decrypt_mode ? OP_SUB_MOD : OP_ADD_MOD;
        alu_req.a = {1'b0, char_val};
        alu_req.b = {1'b0, shift};
        alu_req.m = (char_class == CLS_PRINT) ? PRINT_MOD : CTRL_MOD;
      end
      default: alu_req.op = OP_SUB_GE;
    endcase
  end

  kpsc_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = data_item.message_start ? ST_SUM : ST_KEY;
        end
      end
      ST_SUM: begin
        if (sum_last) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_cnt == '0) begin
          state_next = ST_KEY;
        end
      end
      ST_KEY: begin
        if (pass_count == '0 || char_class == CLS_OTHER) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_PASS;
        end
      end
      ST_PASS: begin
        if (pass_left == 2'd1) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
      pass_count <= 2'd3;
      key_length <= 5'd1;
      key_bytes_low <= '0;
      key_bytes_high <= '0;
    end else if (config_wr.valid && config_wr.ready) begin
      case (config_wr.index)
        CFG_DECRYPT_MODE:   decrypt_mode <= config_wr.data[0];
        CFG_PASS_COUNT:     pass_count <= config_wr.data[1:0];
        CFG_KEY_LENGTH:     key_length <= config_wr.data[4:0];
        CFG_KEY_BYTES_LOW:  key_bytes_low <= config_wr.data;
        CFG_KEY_BYTES_HIGH: key_bytes_high <= config_wr.data;
        default: ;
      endcase
    end
  end

  // Track the key position
  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
    end else if (state == ST_DIV && bit_cnt == '0) begin
      key_position <= alu_res[KEY_IDX_W-1:0];
    end else if (state == ST_KEY) begin
      key_position <= (idx_inc >= n_eff) ? '0 : idx_inc[KEY_IDX_W-1:0];
    end
  end

  // Advance the item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        char_in <= data_item.data_byte;
        key_sum <= '0;
        sum_cnt <= '0;
        rem <= '0;
        bit_cnt <= 4'(KEY_SUM_W - 1);
        if (data_item.data_byte >= PRINT_LO && data_item.data_byte <= PRINT_HI) begin
          char_class <= CLS_PRINT;
          char_val <= 7'(data_item.data_byte - PRINT_LO);
        end else if (data_item.data_byte >= CTRL_LO && data_item.data_byte <= CTRL_HI) begin
          char_class <= CLS_CTRL;
          char_val <= 7'(data_item.data_byte - CTRL_LO);
        end else begin
          char_class <= CLS_OTHER;
          char_val <= '0;
        end
      end
      ST_SUM: begin
        key_sum <= key_sum + {4'b0, key_byte(key_bytes_low, key_bytes_high, sum_cnt)};
        sum_cnt <= sum_cnt + KEY_IDX_W'(1);
      end
      ST_DIV: begin
        rem <= alu_res[4:0];
        key_sum <= {key_sum[KEY_SUM_W-2:0], 1'b0};
        bit_cnt <= bit_cnt - 4'd1;
      end
      ST_KEY: begin
        shift <= (char_class == CLS_PRINT) ? s95 : {5'b0, r3[1:0]};
        pass_left <= pass_count;
      end
      ST_PASS: begin
        char_val <= alu_res[6:0];
        pass_left <= pass_left - 2'd1;
      end
      default: ;
    endcase
  end

  // Hand the result to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (data_result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      case (char_class)
        CLS_PRINT: result_byte <= {1'b0, char_val} + PRINT_LO;
        CLS_CTRL:  result_byte <= {1'b0, char_val} + CTRL_LO;
        default:   result_byte <= char_in;
      endcase
    end
  end

`ifndef SYNTH
  // The block takes no new byte in the cycle after one is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !data_item.ready)
    else $error("accepted a byte while busy");

  // The partial remainder stays below the key length
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < n_eff))
    else $error("remainder out of range");

  // The key position lands inside the key after each byte
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KEY) |=> ({1'b0, key_position} < n_eff))
    else $error("key position beyond key length");

  // A finished byte reaches the output register once it is free
  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not loaded");
`endif
endmodule

@@ sim/keyed_printable_shift_cipher_unit_test.sv @@
// Self-checking testbench for keyed_printable_shift_cipher_unit.
// Drives bytes and register writes, predicts each result byte and compares it.
// Depends on kpsc_pkg, the channel interfaces in kpsc_if and the unit itself.
module keyed_printable_shift_cipher_unit_test;
  import kpsc_pkg::*;

  // Register index with no register behind it, writes must be dropped
  localparam cfg_index_t CFG_UNUSED_INDEX = 3'd5;

  logic clk = 1'b0;
  logic rst;

  kpsc_item_if   item_ch ();
  kpsc_result_if result_ch ();
  kpsc_cfg_if    cfg_ch ();

  keyed_printable_shift_cipher_unit uut (
    .clk         (clk),
    .rst         (rst),
    .data_item   (item_ch),
    .data_result (result_ch),
    .config_wr   (cfg_ch)
  );

  always #4 clk = ~clk;

  // Predictor copy of the registers and the key position
  logic        decrypt_q;
  logic [1:0]  pass_count_q;
  logic [4:0]  key_length_q;
  logic [63:0] key_lo_q;
  logic [63:0] key_hi_q;
  logic [3:0]  key_pos_q;

  logic [7:0] expected_bytes[$];

  // Idle and stall controls, owned by the test sequence
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_len;
  logic hold_req;

  int mismatch_count;
  int bytes_sent;
  int results_checked;
  int reg_writes;

  // One transform pass on one byte
  function automatic logic [7:0] shift_char(input logic [7:0] c, input logic [7:0] k,
                                            input logic dec);
    int v;
    int s;
    if (c >= PRINT_LO && c <= PRINT_HI) begin
      s = k % PRINT_MOD;
      v = c - PRINT_LO;
      v = dec ? (v + PRINT_MOD - s) % PRINT_MOD : (v + s) % PRINT_MOD;
      return 8'(v + PRINT_LO);
    end
    if (c >= CTRL_LO && c <= CTRL_HI) begin
      s = k % CTRL_MOD;
      v = c - CTRL_LO;
      v = dec ? (v + CTRL_MOD - s) % CTRL_MOD : (v + s) % CTRL_MOD;
      return 8'(v + CTRL_LO);
    end
    return c;
  endfunction

  // Work out the cipher byte for one accepted byte and advance the key position
  function automatic logic [7:0] cipher_byte(input logic [7:0] b, input logic st);
    int n;
    int sum;
    int idx;
    logic [127:0] key_word;
    logic [7:0] k;
    logic [7:0] r;
    n = key_length_q;
    if (n == 0) n = 1;
    if (n > KEY_MAX) n = KEY_MAX;
    key_word = {key_hi_q, key_lo_q};
    if (st) begin
      sum = 0;
      for (int i = 0; i < n; i++) sum += key_word[i*8 +: 8];
      key_pos_q = 4'(sum % n);
    end
    // A position left beyond a lowered length counts as zero
    idx = key_pos_q;
    if (idx >= n) idx = 0;
    k = key_word[idx*8 +: 8];
    r = b;
    for (int p = 0; p < pass_count_q; p++) r = shift_char(r, k, decrypt_q);
    idx++;
    if (idx >= n) idx = 0;
    key_pos_q = 4'(idx);
    return r;
  endfunction

  // Receiver: stall at random, hold off on request, check every result transaction
  logic hold_ack;
  int   hold_left;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_ack <= hold_req;
      hold_left <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          $display("%0t: result_byte expected none actual %02h", $time,
                   result_ch.result_byte);
        end else begin
          results_checked++;
          if (result_ch.result_byte !== expected_bytes[0]) begin
            mismatch_count++;
            $display("%0t: result_byte expected %02h actual %02h", $time,
                     expected_bytes[0], result_ch.result_byte);
          end
          void'(expected_bytes.pop_front());
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= hold_len;
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one byte; valid stays high after the transaction so the next one can follow
  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data_byte <= b;
    item_ch.message_start <= st;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    expected_bytes.push_back(cipher_byte(b, st));
    bytes_sent++;
  endtask

  // Stop offering bytes and wait until every expected result has come
  task automatic drain;
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // One register write transaction; the caller lowers valid afterwards
  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_DECRYPT_MODE:   decrypt_q = val[0];
      CFG_PASS_COUNT:     pass_count_q = val[1:0];
      CFG_KEY_LENGTH:     key_length_q = val[4:0];
      CFG_KEY_BYTES_LOW:  key_lo_q = val;
      CFG_KEY_BYTES_HIGH: key_hi_q = val;
      default: ;
    endcase
  endtask

  // Write all registers, with random bits above each field; call only while idle
  task automatic apply_config(input logic dm, input logic [1:0] pc, input logic [4:0] kl,
                              input logic [63:0] lo, input logic [63:0] hi,
                              input logic poke_unused);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_reg(CFG_DECRYPT_MODE, {noise[63:1], dm});
    noise = {$urandom, $urandom};
    write_reg(CFG_PASS_COUNT, {noise[63:2], pc});
    noise = {$urandom, $urandom};
    write_reg(CFG_KEY_LENGTH, {noise[63:5], kl});
    write_reg(CFG_KEY_BYTES_LOW, lo);
    write_reg(CFG_KEY_BYTES_HIGH, hi);
    if (poke_unused) write_reg(CFG_UNUSED_INDEX, {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] random_key_word();
    logic [63:0] w;
    if ($urandom_range(4) == 0) return {$urandom, $urandom};
    for (int i = 0; i < 8; i++) w[i*8 +: 8] = 8'($urandom_range(1, 127));
    return w;
  endfunction

  task automatic randomize_config;
    logic [1:0] pc;
    logic [4:0] kl;
    int sel;
    pc = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    sel = $urandom_range(9);
    if (sel == 0) kl = 5'($urandom_range(0, 31));
    else if (sel == 1) kl = $urandom_range(1) ? 5'd1 : 5'd16;
    else kl = 5'($urandom_range(1, 16));
    apply_config(1'($urandom_range(1)), pc, kl, random_key_word(), random_key_word(),
                 $urandom_range(7) == 0);
  endtask

  // Mostly printable text and control characters, some zeros and arbitrary bytes
  function automatic logic [7:0] random_char();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 8'($urandom_range(32, 126));
    if (sel < 75) return 8'($urandom_range(9, 11));
    if (sel < 82) return 8'd0;
    return 8'($urandom);
  endfunction

  // Messages of random length, most opened by a start flag, with stray restarts
  task automatic send_messages(input int count);
    int msg_left;
    logic st;
    msg_left = 0;
    for (int i = 0; i < count; i++) begin
      if (msg_left == 0) begin
        msg_left = $urandom_range(1, 24);
        st = ($urandom_range(19) != 0);
      end else begin
        st = ($urandom_range(29) == 0);
      end
      send_byte(random_char(), st);
      msg_left--;
    end
  endtask

  // Reconfigure every few dozen bytes
  task automatic run_random(input int count);
    int chunk;
    while (count > 0) begin
      chunk = (count < 40) ? count : $urandom_range(25, 45);
      if (chunk > count) chunk = count;
      drain();
      randomize_config();
      send_messages(chunk);
      count -= chunk;
    end
    drain();
  endtask

  // Reset defaults: zero key, length one, three passes, so bytes come back unchanged
  task automatic test_reset_defaults;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h20, 1'b1);
    drain();
  endtask

  // Field extremes, character class borders, and the key length corner cases
  task automatic test_directed;
    apply_config(1'b0, 2'd1, 5'd16, 64'h0807060504030201, 64'h100F0E0D0C0B0A09, 1'b0);
    send_byte(8'h7E, 1'b1);
    send_byte(8'h20, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    // Walk the position up past where the shorter key ends
    for (int i = 0; i < 6; i++) send_byte(8'(8'h41 + i), 1'b0);
    drain();
    // Lower the length below the current position
    apply_config(1'b0, 2'd1, 5'd5, 64'h0807060504030201, 64'h100F0E0D0C0B0A09, 1'b0);
    send_byte(8'h41, 1'b0);
    drain();
    // Key bytes of zero, 255 and the ends of the normal range, decrypting
    apply_config(1'b1, 2'd3, 5'd4, 64'h000000007F01FF00, 64'h0, 1'b0);
    send_byte(8'h20, 1'b1);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h0B, 1'b0);
    drain();
    // No passes at all
    apply_config(1'b0, 2'd0, 5'd3, 64'h7F7F7F7F7F7F7F7F, 64'h0101010101010101, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h0A, 1'b0);
    drain();
    // Length zero counts as one
    apply_config(1'b0, 2'd2, 5'd0, 64'h0000000000000050, 64'h0, 1'b0);
    send_byte(8'h50, 1'b1);
    send_byte(8'h09, 1'b0);
    drain();
    // Lengths above the maximum clamp to it; a write to an unused index is dropped
    apply_config(1'b1, 2'd3, 5'd31, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1);
    send_byte(8'h33, 1'b1);
    send_byte(8'h7E, 1'b0);
    drain();
    apply_config(1'b0, 2'd3, 5'd17, 64'h0102030405060708, 64'h7F7E7D7C7B7A7978, 1'b0);
    send_byte(8'h7D, 1'b1);
    drain();
  endtask

  task automatic test_random_no_idle;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_random(200);
  endtask

  task automatic test_random_sender_idle;
    tx_idle_pct = 82;
    rx_stall_pct = 0;
    run_random(180);
  endtask

  task automatic test_random_receiver_stall;
    tx_idle_pct = 0;
    rx_stall_pct = 82;
    run_random(180);
  endtask

  task automatic test_random_both_idle;
    tx_idle_pct = 15;
    rx_stall_pct = 15;
    run_random(200);
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming
  task automatic test_backpressure;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    drain();
    randomize_config();
    hold_len = 400;
    hold_req = ~hold_req;
    send_messages(60);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data_byte = 8'h00;
    item_ch.message_start = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_DECRYPT_MODE;
    cfg_ch.data = 64'h0;
    hold_req = 1'b0;
    hold_len = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    mismatch_count = 0;
    bytes_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    decrypt_q = 1'b0;
    pass_count_q = 2'd3;
    key_length_q = 5'd1;
    key_lo_q = 64'h0;
    key_hi_q = 64'h0;
    key_pos_q = 4'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure();

    // Let any stray result surface before the verdict
    drain();
    repeat (40) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected result bytes never arrived", $time, expected_bytes.size());
    end
    $display("Ran %0d bytes through %0d register writes, compared %0d result bytes,",
             bytes_sent, reg_writes, results_checked);
    $display("covering both directions, pass counts 0..3, key lengths 0..31 and stalls.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #8000000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_bytes.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
